FILE: src/pfczc_pkg.sv
// ----------------------------------------------------------------------------
// pfczc_pkg
// Shared types and constants for the PFC zero-crossing sequencer.
// ----------------------------------------------------------------------------
package pfczc_pkg;

  localparam int COUNT_WIDTH         = 10;
  localparam int STABLE_NEEDED       = 4;
  localparam int ZERO_CURRENT_NEEDED = 4;
  localparam int LEVEL_WIDTH         = 15;
  localparam int SAMPLE_WIDTH        = 16;
  localparam int CFG_INDEX_WIDTH     = 4;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [LEVEL_WIDTH-1:0]         level_t;
  typedef logic [COUNT_WIDTH-1:0]         count_t;
  typedef logic [2:0]                     state_code_t;
  typedef logic [CFG_INDEX_WIDTH-1:0]     cfg_index_t;

  localparam state_code_t SEQ_HOLD    = 3'd0;
  localparam state_code_t SEQ_BLANK   = 3'd1;
  localparam state_code_t SEQ_PRELOAD = 3'd2;
  localparam state_code_t SEQ_RAMP    = 3'd3;
  localparam state_code_t SEQ_SYNC    = 3'd4;
  localparam state_code_t SEQ_RUN     = 3'd5;

  localparam cfg_index_t REG_ZERO_CURRENT_LEVEL = 4'd0;
  localparam cfg_index_t REG_EXIT_LEVEL         = 4'd1;
  localparam cfg_index_t REG_ENTER_LEVEL        = 4'd2;
  localparam cfg_index_t REG_MIN_RUN_VOUT       = 4'd3;
  localparam cfg_index_t REG_REVERSE_LEVEL      = 4'd4;
  localparam cfg_index_t REG_BLANK_TOTAL        = 4'd5;
  localparam cfg_index_t REG_RAMP_TOTAL         = 4'd6;
  localparam cfg_index_t REG_SYNC_TOTAL         = 4'd7;

endpackage

FILE: src/pfczc_if.sv
// ----------------------------------------------------------------------------
// pfczc channel interfaces
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface pfczc_in_if;
  import pfczc_pkg::*;
  logic    valid;
  logic    ready;
  sample_t vin;
  sample_t il;
  level_t  vout;
  logic    pll_pol;
  logic    i_sign;
  logic    fault;

  modport source (output valid, vin, il, vout, pll_pol, i_sign, fault, input ready);
  modport sink (input valid, vin, il, vout, pll_pol, i_sign, fault, output ready);
endinterface

interface pfczc_out_if;
  import pfczc_pkg::*;
  logic        valid;
  logic        ready;
  state_code_t seq_state_out;
  logic        stage_disable;
  logic        preload_write;
  logic        main_enable;
  logic        slow_leg_set;
  logic        sync_enable;
  logic        pi_reset;
  count_t      ramp_step;
  logic        ramp_write;
  logic        run_request;
  logic        leg_polarity;

  modport source (output valid, seq_state_out, stage_disable, preload_write, main_enable,
                  slow_leg_set, sync_enable, pi_reset, ramp_step, ramp_write,
                  run_request, leg_polarity, input ready);
  modport sink (input valid, seq_state_out, stage_disable, preload_write, main_enable,
                slow_leg_set, sync_enable, pi_reset, ramp_step, ramp_write,
                run_request, leg_polarity, output ready);
endinterface

interface pfczc_cfg_if;
  import pfczc_pkg::*;
  logic       valid;
  logic       ready;
  cfg_index_t index;
  level_t     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/pfc_zero_cross_sequencer_core.sv
// ----------------------------------------------------------------------------
// pfc_zero_cross_sequencer_core
// Totem-pole PFC zero-crossing sequencer, one request per converter sample.
// ----------------------------------------------------------------------------
// Each sample request on in_chan carries vin, il, vout, the PLL polarity, the
// current sign and the supervisor fault flag. The block steps its sequence
// (hold, blank, preload, ramp, sync, run) once per request and returns one
// result request on out_chan with the new state and one-step command pulses.
// Thresholds and step totals are written on cfg_chan, which is always ready;
// writes are expected only while no sample is in flight.
// A request is captured in an input register and its result is formed in one
// pass of compares and counter updates into the output register; one request
// is taken every cycle while the receiver does not stall.
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more request before in_chan drops ready.
// Reset puts the sequence in hold, clears all counters and polarity targets,
// empties both registers and restores the default thresholds.
// ----------------------------------------------------------------------------
module pfc_zero_cross_sequencer_core (
  input  logic         clk,
  input  logic         rst_n,
  pfczc_in_if.sink     in_chan,
  pfczc_out_if.source  out_chan,
  pfczc_cfg_if.sink    cfg_chan
);
  import pfczc_pkg::*;

  typedef enum logic [2:0] {
    ST_HOLD    = SEQ_HOLD,
    ST_BLANK   = SEQ_BLANK,
    ST_PRELOAD = SEQ_PRELOAD,
    ST_RAMP    = SEQ_RAMP,
    ST_SYNC    = SEQ_SYNC,
    ST_RUN     = SEQ_RUN
  } state_t;

  localparam count_t STABLE_N = COUNT_WIDTH'(STABLE_NEEDED);
  localparam count_t ZC_N     = COUNT_WIDTH'(ZERO_CURRENT_NEEDED);

  function automatic logic [SAMPLE_WIDTH:0] mag(input sample_t v);
    logic signed [SAMPLE_WIDTH:0] w;
    w = {v[SAMPLE_WIDTH-1], v};
    return v[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH+1)'(-w) : (SAMPLE_WIDTH+1)'(w);
  endfunction

  level_t zc_level_r, exit_level_r, enter_level_r, min_vout_r, reverse_level_r;
  count_t blank_total_r, ramp_total_r, sync_total_r;

  logic    s1_valid_r;
  sample_t vin_r, il_r;
  level_t  vout_r;
  logic    pll_r, isign_r, fault_r;

  state_t state_r, state_nxt;
  logic   target_pol_r, target_pol_nxt, target_valid_r, target_valid_nxt;
  logic   hw_pol_r, hw_pol_nxt, hw_valid_r, hw_valid_nxt;
  count_t blank_cnt_r, blank_cnt_nxt, stable_cnt_r, stable_cnt_nxt;
  count_t zc_cnt_r, zc_cnt_nxt, ramp_cnt_r, ramp_cnt_nxt, sync_cnt_r, sync_cnt_nxt;

  logic        out_valid_r;
  state_code_t out_state_r;
  logic        dis_r, pre_r, men_r, slow_r, syn_r, pir_r, rwr_r, run_r, lpol_r;
  count_t      rstep_r;

  logic   dis, pre, men, slow, syn, pir, rwr, run, lpol;
  count_t rstep, ramp_inc, sync_inc;
  logic   to_blank, clear, broken, blank_ok, meas_pol;
  logic [SAMPLE_WIDTH:0]        mag_vin, mag_il;
  logic signed [SAMPLE_WIDTH:0] il_ext, ifb, rev_neg;
  logic   s1_adv;

  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || !out_valid_r || out_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign mag_vin  = mag(vin_r);
  assign mag_il   = mag(il_r);
  assign meas_pol = vin_r[SAMPLE_WIDTH-1];
  assign il_ext   = {il_r[SAMPLE_WIDTH-1], il_r};
  assign ifb      = isign_r ? -il_ext : il_ext;
  assign rev_neg  = -$signed({2'b00, reverse_level_r});
  assign broken   = (mag_vin <= {2'b00, enter_level_r}) || !target_valid_r ||
                    (meas_pol != target_pol_r) || (pll_r != target_pol_r);
  assign ramp_inc = (ramp_cnt_r < ramp_total_r) ? ramp_cnt_r + 1'b1 : ramp_cnt_r;
  assign sync_inc = (sync_cnt_r < sync_total_r) ? sync_cnt_r + 1'b1 : sync_cnt_r;

  always_comb begin
    state_nxt        = state_r;
    target_pol_nxt   = target_pol_r;
    target_valid_nxt = target_valid_r;
    hw_pol_nxt       = hw_pol_r;
    hw_valid_nxt     = hw_valid_r;
    blank_cnt_nxt    = blank_cnt_r;
    stable_cnt_nxt   = stable_cnt_r;
    zc_cnt_nxt       = zc_cnt_r;
    ramp_cnt_nxt     = ramp_cnt_r;
    sync_cnt_nxt     = sync_cnt_r;
    {dis, pre, men, slow, syn, pir, rwr, run, lpol} = '0;
    rstep    = '0;
    to_blank = 1'b0;
    clear    = 1'b0;
    blank_ok = 1'b0;

    if (fault_r || (vout_r < min_vout_r)) begin
      if (state_r != ST_HOLD) begin
        clear     = 1'b1;
        state_nxt = ST_HOLD;
        dis       = 1'b1;
        pir       = 1'b1;
      end
    end else begin
      unique case (state_r)
        ST_HOLD: begin
          to_blank = 1'b1;
        end
        ST_BLANK: begin
          if (blank_cnt_r < blank_total_r) begin
            blank_cnt_nxt = blank_cnt_r + 1'b1;
          end
          if (mag_il <= {2'b00, zc_level_r}) begin
            if (zc_cnt_r < ZC_N) begin
              zc_cnt_nxt = zc_cnt_r + 1'b1;
            end
          end else begin
            zc_cnt_nxt = '0;
          end
          if ((mag_vin >= {2'b00, exit_level_r}) && (meas_pol == pll_r)) begin
            if (!target_valid_r || (target_pol_r != pll_r)) begin
              target_pol_nxt   = pll_r;
              target_valid_nxt = 1'b1;
              stable_cnt_nxt   = COUNT_WIDTH'(1);
            end else if (stable_cnt_r < STABLE_N) begin
              stable_cnt_nxt = stable_cnt_r + 1'b1;
            end
          end else begin
            target_pol_nxt   = 1'b0;
            target_valid_nxt = 1'b0;
            stable_cnt_nxt   = '0;
          end
          blank_ok = (blank_cnt_nxt >= blank_total_r) && (stable_cnt_nxt >= STABLE_N) &&
                     (zc_cnt_nxt >= ZC_N);
          if (blank_ok) begin
            ramp_cnt_nxt = '0;
            state_nxt    = ST_PRELOAD;
            pre          = 1'b1;
            lpol         = target_pol_nxt;
          end
        end
        ST_PRELOAD: begin
          if (broken) begin
            to_blank = 1'b1;
          end else begin
            men       = 1'b1;
            lpol      = target_pol_r;
            state_nxt = ST_RAMP;
          end
        end
        ST_RAMP: begin
          if (broken) begin
            to_blank = 1'b1;
          end else begin
            ramp_cnt_nxt = ramp_inc;
            rwr          = 1'b1;
            rstep        = ramp_inc;
            lpol         = target_pol_r;
            if (ramp_inc >= ramp_total_r) begin
              slow         = 1'b1;
              hw_pol_nxt   = target_pol_r;
              hw_valid_nxt = 1'b1;
              sync_cnt_nxt = '0;
              state_nxt    = ST_SYNC;
            end
          end
        end
        ST_SYNC: begin
          if (broken) begin
            to_blank = 1'b1;
          end else begin
            sync_cnt_nxt = sync_inc;
            if (sync_inc >= sync_total_r) begin
              syn       = 1'b1;
              pir       = 1'b1;
              lpol      = target_pol_r;
              state_nxt = ST_RUN;
            end
          end
        end
        default: begin
          if ((mag_vin <= {2'b00, enter_level_r}) || !hw_valid_r || (pll_r != hw_pol_r) ||
              (ifb < rev_neg)) begin
            to_blank = 1'b1;
          end else begin
            run  = 1'b1;
            lpol = pll_r;
          end
        end
      endcase
    end

    if (to_blank) begin
      clear     = 1'b1;
      state_nxt = ST_BLANK;
      dis       = 1'b1;
      pir       = 1'b1;
    end

    if (clear) begin
      target_pol_nxt   = 1'b0;
      target_valid_nxt = 1'b0;
      hw_pol_nxt       = 1'b0;
      hw_valid_nxt     = 1'b0;
      blank_cnt_nxt    = '0;
      stable_cnt_nxt   = '0;
      zc_cnt_nxt       = '0;
      ramp_cnt_nxt     = '0;
      sync_cnt_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zc_level_r      <= LEVEL_WIDTH'(32);
      exit_level_r    <= LEVEL_WIDTH'(1280);
      enter_level_r   <= LEVEL_WIDTH'(640);
      min_vout_r      <= LEVEL_WIDTH'(12800);
      reverse_level_r <= LEVEL_WIDTH'(64);
      blank_total_r   <= COUNT_WIDTH'(200);
      ramp_total_r    <= COUNT_WIDTH'(64);
      sync_total_r    <= COUNT_WIDTH'(4);
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      state_r         <= ST_HOLD;
      target_pol_r    <= 1'b0;
      target_valid_r  <= 1'b0;
      hw_pol_r        <= 1'b0;
      hw_valid_r      <= 1'b0;
      blank_cnt_r     <= '0;
      stable_cnt_r    <= '0;
      zc_cnt_r        <= '0;
      ramp_cnt_r      <= '0;
      sync_cnt_r      <= '0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        unique case (cfg_chan.index)
          REG_ZERO_CURRENT_LEVEL: zc_level_r      <= cfg_chan.data;
          REG_EXIT_LEVEL:         exit_level_r    <= cfg_chan.data;
          REG_ENTER_LEVEL:        enter_level_r   <= cfg_chan.data;
          REG_MIN_RUN_VOUT:       min_vout_r      <= cfg_chan.data;
          REG_REVERSE_LEVEL:      reverse_level_r <= cfg_chan.data;
          REG_BLANK_TOTAL:        blank_total_r   <= cfg_chan.data[COUNT_WIDTH-1:0];
          REG_RAMP_TOTAL:         ramp_total_r    <= cfg_chan.data[COUNT_WIDTH-1:0];
          REG_SYNC_TOTAL:         sync_total_r    <= cfg_chan.data[COUNT_WIDTH-1:0];
          default: ;
        endcase
      end

      if (in_chan.valid && in_chan.ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        state_r        <= state_nxt;
        target_pol_r   <= target_pol_nxt;
        target_valid_r <= target_valid_nxt;
        hw_pol_r       <= hw_pol_nxt;
        hw_valid_r     <= hw_valid_nxt;
        blank_cnt_r    <= blank_cnt_nxt;
        stable_cnt_r   <= stable_cnt_nxt;
        zc_cnt_r       <= zc_cnt_nxt;
        ramp_cnt_r     <= ramp_cnt_nxt;
        sync_cnt_r     <= sync_cnt_nxt;
      end
    end

    if (in_chan.valid && in_chan.ready) begin
      vin_r   <= in_chan.vin;
      il_r    <= in_chan.il;
      vout_r  <= in_chan.vout;
      pll_r   <= in_chan.pll_pol;
      isign_r <= in_chan.i_sign;
      fault_r <= in_chan.fault;
    end

    if (s1_adv) begin
      out_state_r <= state_code_t'(state_nxt);
      dis_r       <= dis;
      pre_r       <= pre;
      men_r       <= men;
      slow_r      <= slow;
      syn_r       <= syn;
      pir_r       <= pir;
      rstep_r     <= rstep;
      rwr_r       <= rwr;
      run_r       <= run;
      lpol_r      <= lpol;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.seq_state_out = out_state_r;
  assign out_chan.stage_disable = dis_r;
  assign out_chan.preload_write = pre_r;
  assign out_chan.main_enable   = men_r;
  assign out_chan.slow_leg_set  = slow_r;
  assign out_chan.sync_enable   = syn_r;
  assign out_chan.pi_reset      = pir_r;
  assign out_chan.ramp_step     = rstep_r;
  assign out_chan.ramp_write    = rwr_r;
  assign out_chan.run_request   = run_r;
  assign out_chan.leg_polarity  = lpol_r;

endmodule

FILE: src/pfczc_checker.sv
// ----------------------------------------------------------------------------
// pfczc_checker
// Port-level checks on the result channel of the zero-crossing sequencer.
// ----------------------------------------------------------------------------
module pfczc_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input pfczc_pkg::state_code_t   seq_state_out,
  input logic                     stage_disable,
  input logic                     pi_reset,
  input logic                     preload_write,
  input logic                     ramp_write,
  input pfczc_pkg::count_t        ramp_step,
  input logic                     run_request
);
  import pfczc_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(seq_state_out) && $stable(ramp_step))
    else $error("result changed while stalled");

  a_disable_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && stage_disable |->
      pi_reset && (seq_state_out == SEQ_HOLD || seq_state_out == SEQ_BLANK))
    else $error("stage disable outside hold or blank entry");

  a_ramp_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ramp_write |-> (seq_state_out == SEQ_RAMP || seq_state_out == SEQ_SYNC))
    else $error("ramp write outside ramp");

  a_ramp_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !ramp_write |-> ramp_step == '0)
    else $error("ramp step without ramp write");

  a_run_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (run_request || preload_write) |->
      (run_request ? seq_state_out == SEQ_RUN : seq_state_out == SEQ_PRELOAD))
    else $error("command pulse does not match state");

endmodule

bind pfc_zero_cross_sequencer_core pfczc_checker u_pfczc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .seq_state_out (out_chan.seq_state_out),
  .stage_disable (out_chan.stage_disable),
  .pi_reset      (out_chan.pi_reset),
  .preload_write (out_chan.preload_write),
  .ramp_write    (out_chan.ramp_write),
  .ramp_step     (out_chan.ramp_step),
  .run_request   (out_chan.run_request)
);
